// ===== rtl/osc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osc_pkg: shared definitions for the orientation sample conditioner
// Command codes, configuration register indexes, field widths and the
// angle constants in whole degrees.
// ----------------------------------------------------------------------------
package osc_pkg;

    // field widths
    localparam int ANGLE_W   = 15;
    localparam int OMIT_W    = 8;
    localparam int FUNC_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    // default fraction bits of an angle (1/64 degree)
    localparam int ANGLE_FRAC_BITS_DEF = 6;

    // angle constants in degrees
    localparam int FULL_TURN_DEG    = 360;
    localparam int HALF_TURN_DEG    = 180;
    localparam int QUARTER_TURN_DEG = 90;
    localparam int JUMP_LIMIT_DEG   = 20;

    // jump limit after reset: 20 degrees at the default fraction width
    localparam logic [ANGLE_W-1:0] JUMP_LIMIT_RST =
        ANGLE_W'(JUMP_LIMIT_DEG << ANGLE_FRAC_BITS_DEF);

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE      = 3'd0,
        FUNC_CAPTURE     = 3'd1,
        FUNC_TOGGLE_PAN  = 3'd2,
        FUNC_TOGGLE_TILT = 3'd3,
        FUNC_TOGGLE_ROLL = 3'd4
    } func_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OMIT_COUNT = 2'd0,
        CFG_JUMP_LIMIT = 2'd1,
        CFG_FORCE_SEND = 2'd2
    } cfg_idx_t;

endpackage

// ===== rtl/orientation_sample_conditioner_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orientation_sample_conditioner_top: head-tracker sample conditioner
// Decimates tracker samples, rejects unchanged or jumping samples unless force_send
// is set, removes the captured offset, wraps each angle once, applies per-axis signs.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready): one request carries func and the
//   three raw angles; func 0 is a sample, 1 captures the offset, 2 to 4
//   toggle the pan, tilt or roll sign, other codes are dropped.
//   output channel (out_valid / out_ready): zero or one result per sample.
//   config channel (cfg_valid / cfg_ready): index 0 omit_count, 1 jump_limit,
//   2 force_send; always ready; user writes only while the block is idle, not enforced.
// timing
//   a request is registered in the input register, evaluated against the stored
//   state and its result lands in the output register, which raises out_valid.
//   One request per cycle is sustained while no result is held back; the rate
//   is set by the single evaluate stage that updates the state.
// reset and stall
//   reset clears the stored sample, offset, signs, skip counter, valid flags and
//   sets the configuration registers to their defaults; no clearing pass is needed.
//   while a result waits, requests that give no result still flow; one
//   that gives a result holds in the input register and in_ready drops.
// ----------------------------------------------------------------------------
module orientation_sample_conditioner_top
    import osc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // input requests
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [FUNC_W-1:0]           func,
    input  logic signed [ANGLE_W-1:0]   pan_in,
    input  logic signed [ANGLE_W-1:0]   tilt_in,
    input  logic signed [ANGLE_W-1:0]   roll_in,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [ANGLE_W-1:0]   pan_out,
    output logic signed [ANGLE_W-1:0]   tilt_out,
    output logic signed [ANGLE_W-1:0]   roll_out,
    // configuration writes
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    // wrap arithmetic width: difference plus one turn, never below 17 bits
    localparam int DIFF_W    = ANGLE_W + 1;
    localparam int FULL_INT  = FULL_TURN_DEG << ANGLE_FRAC_BITS;
    localparam int HALF_INT  = HALF_TURN_DEG << ANGLE_FRAC_BITS;
    localparam int QUART_INT = QUARTER_TURN_DEG << ANGLE_FRAC_BITS;
    localparam int TURN_BITS = $clog2(FULL_INT) + 2;
    localparam int WRAP_W    = (TURN_BITS > DIFF_W + 1) ? TURN_BITS : DIFF_W + 1;

    localparam logic signed [WRAP_W-1:0] FULL_TURN    = WRAP_W'(FULL_INT);
    localparam logic signed [WRAP_W-1:0] HALF_TURN    = WRAP_W'(HALF_INT);
    localparam logic signed [WRAP_W-1:0] QUARTER_TURN = WRAP_W'(QUART_INT);
    localparam logic signed [WRAP_W-1:0] NEG_HALF     = WRAP_W'(-HALF_INT);
    localparam logic signed [WRAP_W-1:0] NEG_QUARTER  = WRAP_W'(-QUART_INT);

    // jump limit after reset at this fraction width
    localparam logic [ANGLE_W-1:0] JUMP_RST = ANGLE_W'(JUMP_LIMIT_DEG << ANGLE_FRAC_BITS);

    // configuration registers
    logic [OMIT_W-1:0]  omit_count_reg;
    logic [ANGLE_W-1:0] jump_limit_reg;
    logic               force_send_reg;

    // input register
    logic                      s1_valid_reg;
    logic [FUNC_W-1:0]         s1_func_reg;
    logic signed [ANGLE_W-1:0] s1_pan_reg;
    logic signed [ANGLE_W-1:0] s1_tilt_reg;
    logic signed [ANGLE_W-1:0] s1_roll_reg;

    // conditioner state
    logic signed [ANGLE_W-1:0] prev_pan_reg, prev_tilt_reg, prev_roll_reg;
    logic signed [ANGLE_W-1:0] off_pan_reg, off_tilt_reg, off_roll_reg;
    logic                      neg_pan_reg, neg_tilt_reg, neg_roll_reg;
    logic [OMIT_W-1:0]         skip_counter_reg;
    logic [OMIT_W-1:0]         skip_counter_next;

    // result register
    logic                      out_valid_reg;
    logic signed [ANGLE_W-1:0] pan_out_reg, tilt_out_reg, roll_out_reg;

    // evaluate stage signals
    logic                      is_sample;
    logic                      considered;
    logic                      s1_emit;
    logic                      out_free;
    logic                      s1_adv;
    logic                      s1_fire;
    logic signed [DIFF_W-1:0]  d_pan, d_tilt;
    logic [DIFF_W-1:0]         ad_pan, ad_tilt;
    logic signed [DIFF_W-1:0]  p_pan, p_tilt, p_roll;
    logic signed [WRAP_W-1:0]  w_pan, w_tilt, w_roll;
    logic signed [WRAP_W-1:0]  n_pan, n_tilt, n_roll;

    // configuration port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omit_count_reg <= '0;
            jump_limit_reg <= JUMP_RST;
            force_send_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_OMIT_COUNT: omit_count_reg <= cfg_data[OMIT_W-1:0];
                CFG_JUMP_LIMIT: jump_limit_reg <= cfg_data[ANGLE_W-1:0];
                CFG_FORCE_SEND: force_send_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // change and jump checks and decimation
    always_comb
    begin
        is_sample  = (func_t'(s1_func_reg) == FUNC_SAMPLE);
        considered = (skip_counter_reg >= omit_count_reg);
        skip_counter_next = considered ? '0 : skip_counter_reg + 1'b1;

        d_pan  = DIFF_W'(s1_pan_reg) - DIFF_W'(prev_pan_reg);
        d_tilt = DIFF_W'(s1_tilt_reg) - DIFF_W'(prev_tilt_reg);
        ad_pan  = d_pan[DIFF_W-1] ? DIFF_W'(-d_pan) : DIFF_W'(d_pan);
        ad_tilt = d_tilt[DIFF_W-1] ? DIFF_W'(-d_tilt) : DIFF_W'(d_tilt);

        s1_emit = is_sample && considered &&
                  ((((ad_pan != '0) || (ad_tilt != '0)) &&
                    (ad_pan < DIFF_W'(jump_limit_reg)) &&
                    (ad_tilt < DIFF_W'(jump_limit_reg))) || force_send_reg);
    end

    // offset removal, single wrap and sign
    always_comb
    begin
        p_pan  = DIFF_W'(s1_pan_reg) - DIFF_W'(off_pan_reg);
        p_tilt = DIFF_W'(s1_tilt_reg) - DIFF_W'(off_tilt_reg);
        p_roll = DIFF_W'(s1_roll_reg) - DIFF_W'(off_roll_reg);

        w_pan  = WRAP_W'(p_pan);
        w_tilt = WRAP_W'(p_tilt);
        w_roll = WRAP_W'(p_roll);

        if (w_pan > HALF_TURN)              w_pan = w_pan - FULL_TURN;
        else if (w_pan < NEG_HALF)          w_pan = w_pan + FULL_TURN;

        if (w_tilt > QUARTER_TURN)          w_tilt = w_tilt - HALF_TURN;
        else if (w_tilt < NEG_QUARTER)      w_tilt = w_tilt + HALF_TURN;

        if (w_roll > HALF_TURN)             w_roll = w_roll - FULL_TURN;
        else if (w_roll < NEG_HALF)         w_roll = w_roll + FULL_TURN;

        n_pan  = neg_pan_reg  ? -w_pan  : w_pan;
        n_tilt = neg_tilt_reg ? -w_tilt : w_tilt;
        n_roll = neg_roll_reg ? -w_roll : w_roll;
    end

    // flow control: a request leaves the input register unless its result is blocked
    assign out_free = !out_valid_reg || out_ready;
    assign s1_adv   = !s1_valid_reg || !s1_emit || out_free;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = s1_adv;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_adv)
        begin
            s1_func_reg <= func;
            s1_pan_reg  <= pan_in;
            s1_tilt_reg <= tilt_in;
            s1_roll_reg <= roll_in;
        end
    end

    // state update as each request is evaluated
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pan_reg     <= '0;
            prev_tilt_reg    <= '0;
            prev_roll_reg    <= '0;
            off_pan_reg      <= '0;
            off_tilt_reg     <= '0;
            off_roll_reg     <= '0;
            neg_pan_reg      <= 1'b0;
            neg_tilt_reg     <= 1'b0;
            neg_roll_reg     <= 1'b0;
            skip_counter_reg <= '0;
        end
        else if (s1_fire)
        begin
            unique case (func_t'(s1_func_reg))
                FUNC_SAMPLE:
                begin
                    prev_pan_reg     <= s1_pan_reg;
                    prev_tilt_reg    <= s1_tilt_reg;
                    prev_roll_reg    <= s1_roll_reg;
                    skip_counter_reg <= skip_counter_next;
                end
                FUNC_CAPTURE:
                begin
                    off_pan_reg  <= prev_pan_reg;
                    off_tilt_reg <= prev_tilt_reg;
                    off_roll_reg <= prev_roll_reg;
                end
                FUNC_TOGGLE_PAN:  neg_pan_reg  <= !neg_pan_reg;
                FUNC_TOGGLE_TILT: neg_tilt_reg <= !neg_tilt_reg;
                FUNC_TOGGLE_ROLL: neg_roll_reg <= !neg_roll_reg;
                default: ;
            endcase
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && s1_emit;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg && s1_emit)
        begin
            pan_out_reg  <= n_pan[ANGLE_W-1:0];
            tilt_out_reg <= n_tilt[ANGLE_W-1:0];
            roll_out_reg <= n_roll[ANGLE_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign pan_out   = pan_out_reg;
    assign tilt_out  = tilt_out_reg;
    assign roll_out  = roll_out_reg;

`ifndef SYNTHESIS
    // a blocked result must hold back new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_emit && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("request accepted while a result is blocked");

    // a new result only follows an emitting evaluation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_emit))
        else $error("result without an emitting sample");

    // a skipped sample advances the skip counter by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && is_sample && !considered) |=>
            (skip_counter_reg == $past(skip_counter_reg) + 1'b1))
        else $error("skip counter did not advance");

    // offset capture copies the stored sample
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (func_t'(s1_func_reg) == FUNC_CAPTURE)) |=>
            ((off_pan_reg == $past(prev_pan_reg)) &&
             (off_tilt_reg == $past(prev_tilt_reg)) &&
             (off_roll_reg == $past(prev_roll_reg))))
        else $error("offset capture mismatch");
`endif

endmodule
